// File: rtl/lcp_pkg.sv
`timescale 1ns / 1ps
package lcp_pkg;

   // result event codes
   localparam logic [2:0] EV_LAYER_SELECTED = 3'd0;
   localparam logic [2:0] EV_SAMPLE_WRITTEN = 3'd1;
   localparam logic [2:0] EV_INVALID_LAYER  = 3'd2;
   localparam logic [2:0] EV_NO_SELECTION   = 3'd3;
   localparam logic [2:0] EV_INVALID_SAMPLE = 3'd4;
   localparam logic [2:0] EV_LINE_TOO_LONG  = 3'd5;

   // action codes
   localparam logic ACT_DATA    = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   // register indexes
   localparam logic CSR_WIDTH_IN_USE = 1'b0;
   localparam logic CSR_LAYER_LIMIT  = 1'b1;

   // scan phases
   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;

   // characters
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_LAYER   = 8'h6C;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;

   localparam logic [8:0] VALUE_CAP = 9'd511;
   localparam logic [8:0] PIXEL_MAX = 9'd255;

   // line status from the scanner, valid for the word being consumed
   typedef struct packed {
      logic       fin;        // newline closed a non-empty line
      logic       too_long;   // line hit the length cap
      logic       is_layer;
      logic       ok;         // number syntax and sign are fine
      logic [8:0] value;
   } line_stat_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] event_res;
      logic [3:0] layer;
      logic [8:0] column;
      logic [7:0] pixel_value;
      logic       layer_complete;
      logic [4:0] layers_used;
   } result_type;

endpackage

// File: rtl/lcp_line_scanner.sv
`timescale 1ns / 1ps
module lcp_line_scanner
   import lcp_pkg::*;
#(
   parameter int LINE_CAPACITY = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          action,
   input  logic [7:0]    data_byte,
   output line_stat_type stat
);

   localparam int LW = $clog2(LINE_CAPACITY);
   localparam logic [LW-1:0] CHAR_LIMIT = LW'(LINE_CAPACITY - 1);

   logic [LW-1:0] chars_ff, chars_in;
   logic          disc_ff, disc_in;
   logic          is_layer_ff, is_layer_in;
   logic [1:0]    phase_ff, phase_in;
   logic          neg_ff, neg_in;
   logic          digit_seen_ff, digit_seen_in;
   logic          bad_ff, bad_in;
   logic [8:0]    value_ff, value_in;

   logic          is_digit;
   logic          is_blank;
   logic [12:0]   acc;

   assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                     (data_byte == CH_VT) || (data_byte == CH_FF) || (data_byte == CH_CR);
   // value * 10 + digit
   assign acc = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0} +
                {5'd0, data_byte - CH_ZERO};

   always_comb begin
      stat.fin      = 1'b0;
      stat.too_long = 1'b0;
      stat.is_layer = is_layer_ff;
      stat.ok       = !bad_ff && digit_seen_ff && !(neg_ff && (value_ff != 9'd0));
      stat.value    = value_ff;

      chars_in      = chars_ff;
      disc_in       = disc_ff;
      is_layer_in   = is_layer_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      digit_seen_in = digit_seen_ff;
      bad_in        = bad_ff;
      value_in      = value_ff;

      if (action == ACT_RESTART || data_byte == CH_NEWLINE ||
          (!disc_ff && chars_ff >= CHAR_LIMIT)) begin
         if (action == ACT_DATA && data_byte == CH_NEWLINE) begin
            stat.fin = !disc_ff && (chars_ff != '0);
            disc_in  = 1'b0;
         end else if (action == ACT_DATA) begin
            stat.too_long = 1'b1;
            disc_in       = 1'b1;
         end else begin
            disc_in = 1'b0;
         end
         chars_in      = '0;
         is_layer_in   = 1'b0;
         phase_in      = PH_LEAD;
         neg_in        = 1'b0;
         digit_seen_in = 1'b0;
         bad_in        = 1'b0;
         value_in      = '0;
      end else if (!disc_ff) begin
         chars_in = chars_ff + 1'b1;
         if (chars_ff == '0 && data_byte == CH_LAYER) begin
            is_layer_in = 1'b1;
         end else if (!bad_ff) begin
            if (is_digit) begin
               value_in      = (acc > {4'd0, VALUE_CAP}) ? VALUE_CAP : acc[8:0];
               digit_seen_in = 1'b1;
               phase_in      = PH_DIGITS;
            end else if (phase_ff == PH_LEAD && is_blank) begin
               phase_in = phase_ff;
            end else if (phase_ff == PH_LEAD &&
                         (data_byte == CH_PLUS || data_byte == CH_MINUS)) begin
               neg_in   = (data_byte == CH_MINUS);
               phase_in = PH_SIGN;
            end else begin
               bad_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff      <= '0;
         disc_ff       <= 1'b0;
         is_layer_ff   <= 1'b0;
         phase_ff      <= PH_LEAD;
         neg_ff        <= 1'b0;
         digit_seen_ff <= 1'b0;
         bad_ff        <= 1'b0;
         value_ff      <= '0;
      end else if (step) begin
         chars_ff      <= chars_in;
         disc_ff       <= disc_in;
         is_layer_ff   <= is_layer_in;
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         digit_seen_ff <= digit_seen_in;
         bad_ff        <= bad_in;
         value_ff      <= value_in;
      end
   end

endmodule

// File: rtl/lcp_frame_tracker.sv
`timescale 1ns / 1ps
module lcp_frame_tracker
   import lcp_pkg::*;
#(
   parameter int COLUMN_CAPACITY = 512,
   parameter int LAYER_CAPACITY  = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          action,
   input  line_stat_type stat,
   input  logic [9:0]    width_in_use,
   input  logic [4:0]    layer_limit,
   output result_type    res
);

   localparam int CW = $clog2(COLUMN_CAPACITY);
   localparam int WW = (CW + 1 > 10) ? CW + 1 : 10;
   localparam logic [WW-1:0] COL_CAP = WW'(COLUMN_CAPACITY);
   localparam logic [8:0]    LAY_CAP = 9'(LAYER_CAPACITY);

   logic          selected_ff, selected_in;
   logic [3:0]    active_ff, active_in;
   logic [CW-1:0] next_col_ff, next_col_in;
   logic [4:0]    highest_ff, highest_in;

   logic [8:0]    lim;
   logic [WW-1:0] wid;
   logic [WW-1:0] col_plus;
   logic          done;

   assign lim      = ({4'd0, layer_limit} > LAY_CAP) ? LAY_CAP : {4'd0, layer_limit};
   assign wid      = (WW'(width_in_use) > COL_CAP) ? COL_CAP : WW'(width_in_use);
   assign col_plus = WW'(next_col_ff) + 1'b1;
   assign done     = col_plus >= wid;

   always_comb begin
      selected_in = selected_ff;
      active_in   = active_ff;
      next_col_in = next_col_ff;
      highest_in  = highest_ff;

      res                = '0;
      res.valid          = stat.fin || stat.too_long;
      res.event_res      = EV_LINE_TOO_LONG;

      if (action == ACT_RESTART) begin
         selected_in = 1'b0;
         active_in   = '0;
         next_col_in = '0;
      end else if (stat.fin) begin
         if (stat.is_layer) begin
            if (stat.ok && stat.value < lim) begin
               // value is below the clamped limit, so it fits five bits
               if (stat.value[4:0] + 5'd1 > highest_ff) begin
                  highest_in = stat.value[4:0] + 5'd1;
               end
               active_in     = stat.value[3:0];
               next_col_in   = '0;
               selected_in   = 1'b1;
               res.event_res = EV_LAYER_SELECTED;
               res.layer     = stat.value[3:0];
            end else begin
               selected_in   = 1'b0;
               res.event_res = EV_INVALID_LAYER;
            end
         end else if (!selected_ff) begin
            res.event_res = EV_NO_SELECTION;
         end else if (!stat.ok || stat.value > PIXEL_MAX) begin
            res.event_res = EV_INVALID_SAMPLE;
         end else begin
            res.event_res      = EV_SAMPLE_WRITTEN;
            res.layer          = active_ff;
            res.column         = 9'(next_col_ff);
            res.pixel_value    = stat.value[7:0];
            res.layer_complete = done;
            if (done) begin
               next_col_in = '0;
               selected_in = 1'b0;
            end else begin
               next_col_in = col_plus[CW-1:0];
            end
         end
      end
      res.layers_used = highest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_ff <= 1'b0;
         active_ff   <= '0;
         next_col_ff <= '0;
         highest_ff  <= '0;
      end else if (step) begin
         selected_ff <= selected_in;
         active_ff   <= active_in;
         next_col_ff <= next_col_in;
         highest_ff  <= highest_in;
      end
   end

endmodule

// File: rtl/waveform_line_command_parser.sv
`timescale 1ns / 1ps
// an accepted word reaches its result word through the input register, then the result register
// throughput: one word per cycle unless results stall; each byte is parsed in one pass of logic
// between both registers, digits accumulate as they arrive so a newline decides the line at once
// reset: synchronous, active high; clears the parser, the layer tracker and both registers,
// and loads width_in_use = 500, layer_limit = 10
module waveform_line_command_parser
   import lcp_pkg::*;
#(
   parameter int COLUMN_CAPACITY = 512,
   parameter int LAYER_CAPACITY  = 16,
   parameter int LINE_CAPACITY   = 16
) (
   input  logic       clock,
   input  logic       reset,
   // input words
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   // result words
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_res,
   output logic [3:0] rsp_layer,
   output logic [8:0] rsp_column,
   output logic [7:0] rsp_pixel_value,
   output logic       rsp_layer_complete,
   output logic [4:0] rsp_layers_used,
   // configuration writes
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata
);

   // configuration registers
   logic [9:0] width_ff;
   logic [4:0] limit_ff;

   // input register
   logic       in_valid_ff;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;

   // result register
   result_type out_ff;

   logic          out_free;   // result register can take a new word this cycle
   logic          advance;    // the held input word is consumed this cycle
   line_stat_type stat;
   result_type    res;

   assign out_free  = !out_ff.valid || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   // input register refills in the same cycle it drains
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 10'd500;
         limit_ff <= 5'd10;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH_IN_USE: width_ff <= csr_wdata;
            CSR_LAYER_LIMIT:  limit_ff <= csr_wdata[4:0];
            default:          width_ff <= width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_data_byte;
      end
   end

   // line syntax: length, discard, sign, digits
   lcp_line_scanner #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_scanner (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .action    (in_action_ff),
      .data_byte (in_byte_ff),
      .stat      (stat)
   );

   // layer selection, column counting and event forming
   lcp_frame_tracker #(
      .COLUMN_CAPACITY(COLUMN_CAPACITY),
      .LAYER_CAPACITY (LAYER_CAPACITY)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .action       (in_action_ff),
      .stat         (stat),
      .width_in_use (width_ff),
      .layer_limit  (limit_ff),
      .res          (res)
   );

   // words without a result just drop out, the register clears once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (advance) begin
         out_ff <= res;
      end else if (out_free) begin
         out_ff.valid <= 1'b0;
      end
   end

   assign rsp_valid          = out_ff.valid;
   assign rsp_event_res      = out_ff.event_res;
   assign rsp_layer          = out_ff.layer;
   assign rsp_column         = out_ff.column;
   assign rsp_pixel_value    = out_ff.pixel_value;
   assign rsp_layer_complete = out_ff.layer_complete;
   assign rsp_layers_used    = out_ff.layers_used;

endmodule

// File: dv/line_parse_checker.sv
`timescale 1ns / 1ps
module line_parse_checker
   import lcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_event_res,
   input  logic [3:0] rsp_layer,
   input  logic [8:0] rsp_column,
   input  logic [7:0] rsp_pixel_value,
   input  logic       rsp_layer_complete,
   input  logic [4:0] rsp_layers_used,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata,
   output int         fail_count,
   output int         pending,
   output int         results_checked,
   output logic [5:0] events_seen
);

   localparam int LINE_CAP  = 16;
   localparam int COL_CAP   = 512;
   localparam int LAYER_CAP = 16;

   logic [9:0] cfg_width;
   logic [4:0] cfg_limit;

   logic [3:0] line_len;
   logic       dropping;
   logic       layer_line;
   logic [1:0] phase;
   logic       minus;
   logic       have_digit;
   logic       syntax_bad;
   logic [8:0] accum;
   logic       selected;
   logic [3:0] cur_layer;
   logic [8:0] col_ptr;
   logic [4:0] top_layer_count;

   result_type events_due[$];

   function automatic void clear_line();
      line_len   = '0;
      layer_line = 1'b0;
      phase      = PH_LEAD;
      minus      = 1'b0;
      have_digit = 1'b0;
      syntax_bad = 1'b0;
      accum      = '0;
   endfunction

   function automatic void push_event(logic [2:0] ev, logic [3:0] lay, logic [8:0] col,
                                      logic [7:0] pix, logic full);
      result_type r;
      r.valid          = 1'b1;
      r.event_res      = ev;
      r.layer          = lay;
      r.column         = col;
      r.pixel_value    = pix;
      r.layer_complete = full;
      r.layers_used    = top_layer_count;
      events_due.push_back(r);
   endfunction

   // one accepted word through the line parser
   function automatic void predict_word(logic act, logic [7:0] ch);
      int   v;
      int   lim;
      int   w;
      int   nxt;
      logic ok;
      logic full;
      logic [8:0] col;
      if (act == ACT_RESTART) begin
         clear_line();
         dropping  = 1'b0;
         selected  = 1'b0;
         cur_layer = '0;
         col_ptr   = '0;
      end else if (ch == CH_NEWLINE) begin
         if (!dropping && line_len != 0) begin
            ok = !syntax_bad && have_digit && !(minus && accum != 0);
            if (layer_line) begin
               lim = (cfg_limit > LAYER_CAP) ? LAYER_CAP : int'(cfg_limit);
               if (ok && int'(accum) < lim) begin
                  if (int'(accum) + 1 > int'(top_layer_count))
                     top_layer_count = 5'(int'(accum) + 1);
                  cur_layer = accum[3:0];
                  col_ptr   = '0;
                  selected  = 1'b1;
                  push_event(EV_LAYER_SELECTED, cur_layer, '0, '0, 1'b0);
               end else begin
                  selected = 1'b0;
                  push_event(EV_INVALID_LAYER, '0, '0, '0, 1'b0);
               end
            end else if (!selected) begin
               push_event(EV_NO_SELECTION, '0, '0, '0, 1'b0);
            end else if (!ok || accum > PIXEL_MAX) begin
               push_event(EV_INVALID_SAMPLE, '0, '0, '0, 1'b0);
            end else begin
               w    = (cfg_width > COL_CAP) ? COL_CAP : int'(cfg_width);
               col  = col_ptr;
               nxt  = int'(col_ptr) + 1;
               full = (nxt >= w);
               if (full) begin
                  col_ptr  = '0;
                  selected = 1'b0;
               end else begin
                  col_ptr = 9'(nxt);
               end
               push_event(EV_SAMPLE_WRITTEN, cur_layer, col, accum[7:0], full);
            end
         end
         clear_line();
         dropping = 1'b0;
      end else if (dropping) begin
         // rest of an overlong line is dropped
      end else if (int'(line_len) < LINE_CAP - 1) begin
         if (line_len == 0 && ch == CH_LAYER) begin
            layer_line = 1'b1;
         end else if (!syntax_bad) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
               v          = int'(accum) * 10 + (int'(ch) - int'(CH_ZERO));
               accum      = (v > int'(VALUE_CAP)) ? VALUE_CAP : 9'(v);
               have_digit = 1'b1;
               phase      = PH_DIGITS;
            end else if (phase == PH_LEAD &&
                         ch inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR}) begin
               // leading blank
            end else if (phase == PH_LEAD && (ch == CH_PLUS || ch == CH_MINUS)) begin
               minus = (ch == CH_MINUS);
               phase = PH_SIGN;
            end else begin
               syntax_bad = 1'b1;
            end
         end
         line_len = line_len + 4'd1;
      end else begin
         clear_line();
         dropping = 1'b1;
         push_event(EV_LINE_TOO_LONG, '0, '0, '0, 1'b0);
      end
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cfg_width = 10'd500;
         cfg_limit = 5'd10;
         clear_line();
         dropping        = 1'b0;
         selected        = 1'b0;
         cur_layer       = '0;
         col_ptr         = '0;
         top_layer_count = '0;
         events_seen     = '0;
         events_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (events_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: event %0d layer %0d column %0d pixel %0d",
                           rsp_event_res, rsp_layer, rsp_column, rsp_pixel_value);
            end else begin
               want = events_due.pop_front();
               results_checked++;
               events_seen[want.event_res] = 1'b1;
               if (rsp_event_res !== want.event_res || rsp_layer !== want.layer ||
                   rsp_column !== want.column || rsp_pixel_value !== want.pixel_value ||
                   rsp_layer_complete !== want.layer_complete ||
                   rsp_layers_used !== want.layers_used) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch on result %0d", results_checked);
                     $display("   expected ev %0d lay %0d col %0d pix %0d done %0d used %0d",
                              want.event_res, want.layer, want.column, want.pixel_value,
                              want.layer_complete, want.layers_used);
                     $display("   got ev %0d lay %0d col %0d pix %0d done %0d used %0d",
                              rsp_event_res, rsp_layer, rsp_column, rsp_pixel_value,
                              rsp_layer_complete, rsp_layers_used);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            predict_word(req_action, req_data_byte);
         if (csr_we) begin
            if (csr_index == CSR_WIDTH_IN_USE)
               cfg_width = csr_wdata;
            else
               cfg_limit = csr_wdata[4:0];
         end
      end
      pending = events_due.size();
   end

endmodule

// File: dv/tb_waveform_line_command_parser.sv
`timescale 1ns / 1ps
module tb_waveform_line_command_parser;
   import lcp_pkg::*;

   // run shape
   localparam int PHASE_WORDS   = 205;   // random words per register setting
   localparam int SETTINGS      = 7;
   localparam int SETTLE_CYCLES = 8;     // covers the two-stage pipe with margin
   localparam int HOLD_AT       = 900;   // input word count that starts the long back-pressure
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 3000;  // cycles with no word moving on either side

   // register settings, extremes included (0 and 1023 width, 0 and 31 limit)
   localparam logic [SETTINGS-1:0][9:0] WIDTHS =
      {10'd7, 10'd2, 10'd512, 10'd1023, 10'd3, 10'd0, 10'd1};
   localparam logic [SETTINGS-1:0][4:0] LIMITS =
      {5'd16, 5'd5, 5'd10, 5'd31, 5'd1, 5'd0, 5'd16};

   localparam logic [4:0][7:0] BLANKS = {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_action;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_event_res;
   logic [3:0] rsp_layer;
   logic [8:0] rsp_column;
   logic [7:0] rsp_pixel_value;
   logic       rsp_layer_complete;
   logic [4:0] rsp_layers_used;
   logic       csr_we;
   logic       csr_index;
   logic [9:0] csr_wdata;

   int         fail_count;
   int         pending;
   int         results_checked;
   logic [5:0] events_seen;

   // stimulus bookkeeping
   int         words_sent    = 0;
   int         restarts      = 0;
   int         settings_done = 0;
   int         limit_now     = 10;
   int         quiet_cycles  = 0;
   bit         idle_on       = 1'b1;
   bit         stall_on      = 1'b1;
   logic [7:0] line_bytes[$];

   always #1 clock = ~clock;

   waveform_line_command_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_layer          (rsp_layer),
      .rsp_column         (rsp_column),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_layer_complete (rsp_layer_complete),
      .rsp_layers_used    (rsp_layers_used),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   line_parse_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_layer          (rsp_layer),
      .rsp_column         (rsp_column),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_layer_complete (rsp_layer_complete),
      .rsp_layers_used    (rsp_layers_used),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending            (pending),
      .results_checked    (results_checked),
      .events_seen        (events_seen)
   );

   // offer one word, with a random gap first while idling is on;
   // valid only drops in a gap, so back-to-back words keep it high
   task automatic send_word(input logic act, input logic [7:0] b);
      while (idle_on && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= b;
      // req_ready read right after the edge still shows its value at that edge
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // append text to the pending line, close it with a newline and send it all
   task automatic send_text(input string s);
      foreach (s[i]) line_bytes.push_back(s[i]);
      line_bytes.push_back(CH_NEWLINE);
      foreach (line_bytes[i]) send_word(ACT_DATA, line_bytes[i]);
      line_bytes.delete();
   endtask

   // decimal number with the odd leading blank, sign or leading zero
   task automatic add_number(input int value);
      string digits;
      int    sign_pick;
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 2)) line_bytes.push_back(BLANKS[$urandom_range(4)]);
      sign_pick = $urandom_range(19);
      if (sign_pick == 0)
         line_bytes.push_back(CH_PLUS);
      else if (sign_pick == 1)
         line_bytes.push_back(CH_MINUS);
      if ($urandom_range(9) == 0)
         line_bytes.push_back(CH_ZERO);
      digits = $sformatf("%0d", value);
      foreach (digits[i]) line_bytes.push_back(digits[i]);
   endtask

   // mostly well-formed layer selects and samples, the rest noise and broken lines
   task automatic send_random_line();
      int pick;
      int eff_limit;
      pick      = $urandom_range(99);
      eff_limit = (limit_now > 16) ? 16 : limit_now;
      if (pick < 3) begin
         // restart, the byte rides along and is ignored
         send_word(ACT_RESTART, 8'($urandom_range(255)));
         restarts++;
      end else begin
         if (pick < 6) begin
            // empty line
         end else if (pick < 30) begin
            line_bytes.push_back(CH_LAYER);
            if (eff_limit > 0 && $urandom_range(99) < 85)
               add_number($urandom_range(eff_limit - 1));
            else
               add_number($urandom_range(40));
         end else if (pick < 80) begin
            if ($urandom_range(9) != 0)
               add_number($urandom_range(255));
            else
               add_number($urandom_range(2000, 256));
         end else if (pick < 87) begin
            // number spoiled by a stray character
            if ($urandom_range(1))
               line_bytes.push_back(CH_LAYER);
            add_number($urandom_range(300));
            line_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
         end else if (pick < 93) begin
            // raw noise, any byte value
            repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(255)));
         end else if (pick < 97) begin
            // long line, overlong when it holds more than 15 bytes
            repeat ($urandom_range(15, 22))
               line_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
         end else begin
            // blanks or a lone sign, no digits
            repeat ($urandom_range(1, 3)) line_bytes.push_back(BLANKS[$urandom_range(4)]);
            if ($urandom_range(1))
               line_bytes.push_back(CH_MINUS);
         end
         send_text("");
      end
   endtask

   // stop offering and wait until every predicted result has come back,
   // then let words with no result clear the pipe
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls, plus one long hold-off in the middle of the run
   initial begin : receiver
      int words_seen;
      bit held;
      words_seen = 0;
      held       = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && req_valid && req_ready)
            words_seen++;
         if (!held && words_seen >= HOLD_AT) begin
            // sender keeps offering, so the block fills and stalls its input
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= !stall_on || ($urandom_range(99) >= 31);
      end
   end

   // watchdog on traffic in either direction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", quiet_cycles);
         $display("tb_waveform_line_command_parser NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase_end;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_DATA;
      req_data_byte = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_WIDTH_IN_USE;
      csr_wdata     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines on the reset settings: width 500, layer limit 10
      send_text("5");                 // sample with no layer selected
      send_text("");                  // empty line, no result
      send_text("l3");
      send_text("255");               // top pixel value
      line_bytes.push_back(CH_SPACE);
      line_bytes.push_back(CH_TAB);
      send_text("+0");                // leading blanks and plus sign
      send_text("-0");                // negative zero is fine
      send_text("-5");                // negative nonzero
      send_text("99999");             // accumulator saturates
      send_text("25x");               // junk after digits
      line_bytes.push_back("1");
      line_bytes.push_back(8'h00);
      send_text("");                  // nul inside a number
      send_text("+");                 // sign with no digits
      send_text("l10");               // at the layer limit, drops the selection
      send_text("7");
      send_text("l-0");               // layer zero with a minus sign
      send_text("l");                 // layer with no digits
      send_text("l9");
      send_text("0123456789abcdefgh");  // overlong, tail dropped
      line_bytes.push_back(CH_VT);
      line_bytes.push_back(CH_FF);
      line_bytes.push_back(CH_CR);
      send_text("12");
      send_word(ACT_RESTART, 8'hFF);
      restarts++;
      send_text("1");                 // selection gone after restart

      // random phases, one per register setting; the third runs without idling
      for (int p = 0; p < SETTINGS; p++) begin
         drain();
         idle_on  = (p != 2);
         stall_on = (p != 2);
         csr_we    <= 1'b1;
         csr_index <= CSR_WIDTH_IN_USE;
         csr_wdata <= WIDTHS[p];
         @(posedge clock);
         csr_index <= CSR_LAYER_LIMIT;
         csr_wdata <= {5'd0, LIMITS[p]};
         @(posedge clock);
         csr_we <= 1'b0;
         limit_now = LIMITS[p];
         settings_done++;
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) send_random_line();
      end
      drain();

      $display("run: %0d input words incl. %0d restarts, reset setting plus %0d written ones",
               words_sent, restarts, settings_done);
      $display("run: %0d result words checked, event kinds seen %b, %0d failures",
               results_checked, events_seen, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("tb_waveform_line_command_parser OK");
      else
         $display("tb_waveform_line_command_parser NOT OK");
      $finish;
   end

endmodule
